// ===== hdl/led_bar_countdown_timer_defines.svh =====
// Assertion macros used by the port-level checker of the LED bar countdown timer
`ifndef LED_BAR_COUNTDOWN_TIMER_DEFINES_SVH
`define LED_BAR_COUNTDOWN_TIMER_DEFINES_SVH

// check cons in the same cycle as ante
`define LBCT_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lbct assertion failed");

// check cons in the cycle after ante
`define LBCT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lbct assertion failed");

`endif

// ===== hdl/lbct_pkg.sv =====
// Types, constants and next-state helpers of the LED bar countdown timer
package lbct_pkg;

	localparam logic [4:0] ANIM_FRAMES = 5'd30;
	localparam logic [7:0] LAST_LED_RESET = 8'd59;
	localparam logic [6:0] RUN_LEN_RESET = 7'd16;
	localparam logic [6:0] TICK_MAX = 7'd127;
	localparam logic [7:0] LEVEL_ON = 8'hFF;
	localparam int PADDR_W = 3;

	localparam logic [7:0] CH_G = 8'h47;
	localparam logic [7:0] CH_S = 8'h53;
	localparam logic [7:0] CH_0 = 8'h30;
	localparam logic [7:0] CH_1 = 8'h31;
	localparam logic [7:0] CH_2 = 8'h32;
	localparam logic [7:0] CH_3 = 8'h33;
	localparam logic [7:0] CH_4 = 8'h34;
	localparam logic [7:0] CH_5 = 8'h35;
	localparam logic [7:0] CH_6 = 8'h36;
	localparam logic [7:0] CH_7 = 8'h37;
	localparam logic [7:0] CH_8 = 8'h38;

	typedef enum logic [1:0] {
		CMD_BYTE  = 2'd0,
		CMD_TICK  = 2'd1,
		CMD_FRAME = 2'd2,
		CMD_PIXEL = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		MODE_IDLE    = 2'd0,
		MODE_COUNT   = 2'd1,
		MODE_START   = 2'd2,
		MODE_STOP    = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		DISP_DARK     = 3'd0,
		DISP_RUN      = 3'd1,
		DISP_PRESTART = 3'd2,
		DISP_PRESTOP  = 3'd3,
		DISP_ALLRED   = 3'd4
	} disp_t;

	typedef enum logic [0:0] {
		REG_LAST_LED = 1'b0
	} reg_idx_t;

	typedef struct packed {
		mode_t       mode;
		disp_t       disp;
		logic [7:0]  offset;
		logic [4:0]  anim;
		logic [6:0]  tick;
		logic [6:0]  len;
		logic [7:0]  held;
		logic        held_vld;
	} st_t;

	typedef struct packed {
		st_t  st;
		logic changed;
	} act_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       frame_changed;
		logic [1:0] run_mode;
		logic [7:0] position;
	} result_t;

	function automatic act_t act_on_byte(st_t s, logic [7:0] b);
		act_t a;
		a.st = s;
		a.changed = 1'b0;
		unique case (b)
			CH_G: begin
				a.st.mode = MODE_START;
				a.st.anim = ANIM_FRAMES;
				a.st.disp = DISP_PRESTART;
				a.changed = 1'b1;
			end
			CH_S: begin
				a.st.mode = MODE_STOP;
				a.st.anim = ANIM_FRAMES;
				a.st.disp = DISP_PRESTOP;
				a.changed = 1'b1;
			end
			CH_0: begin
				a.st.mode = MODE_IDLE;
				a.st.disp = DISP_DARK;
				a.changed = 1'b1;
			end
			CH_1: a.st.len = 7'd4;
			CH_2: a.st.len = 7'd8;
			CH_3: a.st.len = 7'd12;
			CH_4: a.st.len = 7'd16;
			CH_5: a.st.len = 7'd24;
			CH_6: a.st.len = 7'd32;
			CH_7: a.st.len = 7'd48;
			CH_8: a.st.len = 7'd64;
			default: a.changed = 1'b0;
		endcase
		return a;
	endfunction

endpackage

// ===== hdl/lbct_channels.sv =====
// Valid/ready channel interfaces for timer events and results
interface lbct_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] command;
	logic [7:0] data_byte;
	logic [7:0] pixel_index;

	modport source (output valid, input ready, output command, output data_byte,
		output pixel_index);
	modport sink (input valid, output ready, input command, input data_byte,
		input pixel_index);
endinterface

interface lbct_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic       frame_changed;
	logic [1:0] run_mode;
	logic [7:0] position;

	modport source (output valid, input ready, output red, output green, output blue,
		output frame_changed, output run_mode, output position);
	modport sink (input valid, output ready, input red, input green, input blue,
		input frame_changed, input run_mode, input position);
endinterface

// ===== hdl/led_bar_countdown_timer.sv =====
// Top level of the LED bar countdown timer: event decode, timer state and pixel colour
// An accepted event's result is in the output register in the cycle after it is accepted.
// Throughput: one event per cycle; the output register takes a new result in the
// cycle its current one is taken, so req.ready only drops while rsp is stalled.
// Reset (arst_n low, asynchronous): stopped, dark, offset 0, run length 16 ticks,
// no held byte, last LED index 59, output empty.
module led_bar_countdown_timer (
	input  logic                            clk,
	input  logic                            arst_n,
	lbct_req_if.sink                        req,
	lbct_rsp_if.source                      rsp,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [lbct_pkg::PADDR_W-1:0]    paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);

	lbct_pkg::st_t     state_q;
	lbct_pkg::st_t     state_n;
	lbct_pkg::result_t rsp_q;
	lbct_pkg::result_t res_n;
	lbct_pkg::act_t    act;
	lbct_pkg::cmd_t    cmd;
	logic [7:0]        last_led_q;
	logic              rsp_vld_q;
	logic              accept;
	logic              take;
	logic              changed;
	logic [6:0]        tick_inc;
	logic [7:0]        off_inc;
	logic [4:0]        anim_dec;
	logic [7:0]        pix_o;
	logic [7:0]        pix_m;
	logic              reg_sel;

	// configuration port
	assign pready  = 1'b1;
	assign reg_sel = (lbct_pkg::reg_idx_t'(paddr[lbct_pkg::PADDR_W-1])
		== lbct_pkg::REG_LAST_LED);
	assign prdata  = reg_sel ? {24'd0, last_led_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_led_q <= lbct_pkg::LAST_LED_RESET;
		end else if (psel && penable && pwrite && reg_sel) begin
			last_led_q <= pwdata[7:0];
		end
	end

	// handshake
	assign take      = !rsp_vld_q || rsp.ready;
	assign req.ready = take;
	assign accept    = req.valid && take;
	assign cmd       = lbct_pkg::cmd_t'(req.command);

	assign tick_inc = (state_q.tick == lbct_pkg::TICK_MAX) ? state_q.tick
		: state_q.tick + 7'd1;
	assign off_inc  = state_q.offset + 8'd1;
	assign anim_dec = (state_q.anim != 5'd0) ? state_q.anim - 5'd1 : 5'd0;

	always_comb begin
		state_n = state_q;
		changed = 1'b0;
		act     = '0;
		unique case (cmd)
			lbct_pkg::CMD_BYTE: begin
				if (state_q.mode == lbct_pkg::MODE_START
					|| state_q.mode == lbct_pkg::MODE_STOP) begin
					state_n.held     = req.data_byte;
					state_n.held_vld = 1'b1;
				end else begin
					act     = lbct_pkg::act_on_byte(state_q, req.data_byte);
					state_n = act.st;
					changed = act.changed;
				end
			end
			lbct_pkg::CMD_TICK: begin
				if (state_q.mode == lbct_pkg::MODE_COUNT) begin
					state_n.tick = tick_inc;
					if (tick_inc >= state_q.len) begin
						state_n.offset = off_inc;
						changed        = 1'b1;
						if (off_inc > {1'b0, last_led_q[7:1]}) begin
							state_n.mode = lbct_pkg::MODE_STOP;
							state_n.anim = lbct_pkg::ANIM_FRAMES;
							state_n.disp = lbct_pkg::DISP_PRESTOP;
						end else begin
							state_n.disp = lbct_pkg::DISP_RUN;
							state_n.tick = 7'd0;
						end
					end
				end
			end
			lbct_pkg::CMD_FRAME: begin
				if (state_q.mode == lbct_pkg::MODE_START
					|| state_q.mode == lbct_pkg::MODE_STOP) begin
					state_n.anim = anim_dec;
					changed      = 1'b1;
					if (anim_dec == 5'd0) begin
						if (state_q.mode == lbct_pkg::MODE_START) begin
							state_n.mode     = lbct_pkg::MODE_COUNT;
							state_n.offset   = 8'd0;
							state_n.tick     = 7'd0;
							state_n.disp     = lbct_pkg::DISP_RUN;
							state_n.held_vld = 1'b0;
						end else begin
							state_n.mode     = lbct_pkg::MODE_IDLE;
							state_n.disp     = lbct_pkg::DISP_ALLRED;
							state_n.held_vld = 1'b0;
							// replay the byte that arrived during the animation
							if (state_q.held_vld) begin
								act     = lbct_pkg::act_on_byte(state_n, state_q.held);
								state_n = act.st;
							end
						end
					end
				end
			end
			lbct_pkg::CMD_PIXEL: begin
				state_n = state_q;
			end
		endcase
	end

	// pixel colour from the current state
	assign pix_o = (state_q.disp == lbct_pkg::DISP_RUN) ? state_q.offset
		: {3'd0, state_q.anim};
	assign pix_m = last_led_q - pix_o;

	always_comb begin
		res_n       = '0;
		if (cmd == lbct_pkg::CMD_PIXEL && req.pixel_index <= last_led_q) begin
			if (state_q.disp == lbct_pkg::DISP_ALLRED) begin
				res_n.red = lbct_pkg::LEVEL_ON;
			end else if (pix_o <= last_led_q) begin
				unique case (state_q.disp)
					lbct_pkg::DISP_RUN: begin
						if (req.pixel_index == pix_o || req.pixel_index == pix_m) begin
							res_n.red   = lbct_pkg::LEVEL_ON;
							res_n.green = lbct_pkg::LEVEL_ON;
						end else if (req.pixel_index > pix_o && req.pixel_index < pix_m) begin
							res_n.green = lbct_pkg::LEVEL_ON;
						end
					end
					lbct_pkg::DISP_PRESTART: begin
						if (req.pixel_index == pix_o || req.pixel_index == pix_m) begin
							res_n.blue = lbct_pkg::LEVEL_ON;
						end
					end
					lbct_pkg::DISP_PRESTOP: begin
						if (req.pixel_index >= pix_o && req.pixel_index <= pix_m) begin
							res_n.red = lbct_pkg::LEVEL_ON;
						end
					end
					default: res_n.red = 8'd0;
				endcase
			end
		end
		res_n.frame_changed = changed;
		res_n.run_mode      = state_n.mode;
		res_n.position      = (state_n.mode == lbct_pkg::MODE_START
			|| state_n.mode == lbct_pkg::MODE_STOP) ? {3'd0, state_n.anim} : state_n.offset;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{mode: lbct_pkg::MODE_IDLE, disp: lbct_pkg::DISP_DARK,
				offset: 8'd0, anim: 5'd0, tick: 7'd0, len: lbct_pkg::RUN_LEN_RESET,
				held: 8'd0, held_vld: 1'b0};
			rsp_vld_q <= 1'b0;
		end else begin
			if (accept) begin
				state_q <= state_n;
			end
			if (take) begin
				rsp_vld_q <= accept;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= res_n;
		end
	end

	assign rsp.valid         = rsp_vld_q;
	assign rsp.red           = rsp_q.red;
	assign rsp.green         = rsp_q.green;
	assign rsp.blue          = rsp_q.blue;
	assign rsp.frame_changed = rsp_q.frame_changed;
	assign rsp.run_mode      = rsp_q.run_mode;
	assign rsp.position      = rsp_q.position;

endmodule

// ===== hdl/lbct_checker.sv =====
// Port-level checker for the LED bar countdown timer, bound to the top level
`include "led_bar_countdown_timer_defines.svh"

module lbct_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] red,
	input logic [7:0] green,
	input logic [7:0] blue,
	input logic       frame_changed,
	input logic [1:0] run_mode,
	input logic [7:0] position
);

	`LBCT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(position) && $stable(red) && $stable(run_mode))
	`LBCT_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready)
	`LBCT_ASSERT_NOW(a_change_no_colour, out_valid && frame_changed, red == 8'd0 && green == 8'd0 && blue == 8'd0)
	`LBCT_ASSERT_NOW(a_anim_position, out_valid && (run_mode == lbct_pkg::MODE_START || run_mode == lbct_pkg::MODE_STOP), position <= 8'(lbct_pkg::ANIM_FRAMES))

endmodule

bind led_bar_countdown_timer lbct_checker u_lbct_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (req.valid),
	.in_ready      (req.ready),
	.out_valid     (rsp.valid),
	.out_ready     (rsp.ready),
	.red           (rsp.red),
	.green         (rsp.green),
	.blue          (rsp.blue),
	.frame_changed (rsp.frame_changed),
	.run_mode      (rsp.run_mode),
	.position      (rsp.position)
);

// ===== tb/lbct_timer_checker.sv =====
// Checker for the LED bar countdown timer: tracks timer state and compares every result
module lbct_timer_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	lbct_req_if                          evt,
	lbct_rsp_if                          res,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic                         pready,
	input  logic [lbct_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output int                           mismatch_count,
	output int                           awaited
);
	import lbct_pkg::*;

	mode_t      mode;
	disp_t      disp;
	logic [7:0] offset;
	logic [4:0] anim;
	logic [6:0] ticks;
	logic [6:0] len;
	logic [7:0] held;
	logic       held_vld;
	logic [7:0] last_led;
	result_t    timer_results[$];
	result_t    want;
	result_t    got;

	function automatic void enter_stop_anim();
		mode = MODE_STOP;
		anim = ANIM_FRAMES;
		disp = DISP_PRESTOP;
	endfunction

	function automatic logic take_byte(input logic [7:0] b);
		logic shown;
		shown = 1'b0;
		case (b)
			CH_G: begin
				mode = MODE_START;
				anim = ANIM_FRAMES;
				disp = DISP_PRESTART;
				shown = 1'b1;
			end
			CH_S: begin
				enter_stop_anim();
				shown = 1'b1;
			end
			CH_0: begin
				mode = MODE_IDLE;
				disp = DISP_DARK;
				shown = 1'b1;
			end
			CH_1: len = 7'd4;
			CH_2: len = 7'd8;
			CH_3: len = 7'd12;
			CH_4: len = 7'd16;
			CH_5: len = 7'd24;
			CH_6: len = 7'd32;
			CH_7: len = 7'd48;
			CH_8: len = 7'd64;
			default: shown = 1'b0;
		endcase
		return shown;
	endfunction

	task automatic advance_timer(input cmd_t cmd, input logic [7:0] b, input logic [7:0] pix,
		output result_t r);
		logic [7:0] o;
		logic [7:0] far;
		logic       animating;
		r = '0;
		animating = (mode == MODE_START) || (mode == MODE_STOP);
		case (cmd)
			CMD_BYTE: begin
				if (animating) begin
					held = b;
					held_vld = 1'b1;
				end else begin
					r.frame_changed = take_byte(b);
				end
			end
			CMD_TICK: begin
				if (mode == MODE_COUNT) begin
					if (ticks < TICK_MAX)
						ticks = ticks + 7'd1;
					if (ticks >= len) begin
						offset = offset + 8'd1;
						if (offset > (last_led >> 1)) begin
							enter_stop_anim();
						end else begin
							disp = DISP_RUN;
							ticks = '0;
						end
						r.frame_changed = 1'b1;
					end
				end
			end
			CMD_FRAME: begin
				if (animating) begin
					if (anim != 5'd0)
						anim = anim - 5'd1;
					r.frame_changed = 1'b1;
					if (anim == 5'd0) begin
						if (mode == MODE_START) begin
							mode = MODE_COUNT;
							offset = '0;
							ticks = '0;
							disp = DISP_RUN;
							held_vld = 1'b0;
						end else begin
							mode = MODE_IDLE;
							disp = DISP_ALLRED;
							if (held_vld) begin
								held_vld = 1'b0;
								void'(take_byte(held));
							end
						end
					end
				end
			end
			default: begin
				o = (disp == DISP_RUN) ? offset : {3'b000, anim};
				if (pix <= last_led) begin
					if (disp == DISP_ALLRED) begin
						r.red = LEVEL_ON;
					end else if (disp != DISP_DARK && o <= last_led) begin
						far = last_led - o;
						case (disp)
							DISP_RUN: begin
								if (pix == o || pix == far) begin
									r.red = LEVEL_ON;
									r.green = LEVEL_ON;
								end else if (pix > o && pix < far) begin
									r.green = LEVEL_ON;
								end
							end
							DISP_PRESTART: begin
								if (pix == o || pix == far)
									r.blue = LEVEL_ON;
							end
							DISP_PRESTOP: begin
								if (pix >= o && pix <= far)
									r.red = LEVEL_ON;
							end
							default: ;
						endcase
					end
				end
			end
		endcase
		r.run_mode = mode;
		r.position = ((mode == MODE_START) || (mode == MODE_STOP)) ? {3'b000, anim} : offset;
	endtask

	task automatic check_field(input string field, input logic [7:0] exp_val,
		input logic [7:0] act_val);
		if (exp_val !== act_val) begin
			$error("%s expected %0h actual %0h", field, exp_val, act_val);
			mismatch_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode = MODE_IDLE;
			disp = DISP_DARK;
			offset = '0;
			anim = '0;
			ticks = '0;
			len = RUN_LEN_RESET;
			held = '0;
			held_vld = 1'b0;
			last_led = LAST_LED_RESET;
			timer_results.delete();
			mismatch_count = 0;
		end else begin
			if (res.valid && res.ready) begin
				if (timer_results.size() == 0) begin
					$error("result transaction with no event waiting");
					mismatch_count++;
				end else begin
					want = timer_results.pop_front();
					check_field("red", want.red, res.red);
					check_field("green", want.green, res.green);
					check_field("blue", want.blue, res.blue);
					check_field("frame_changed", 8'(want.frame_changed), 8'(res.frame_changed));
					check_field("run_mode", 8'(want.run_mode), 8'(res.run_mode));
					check_field("position", want.position, res.position);
				end
			end
			if (psel && penable && pwrite && pready
				&& paddr == PADDR_W'(4 * REG_LAST_LED))
				last_led = pwdata[7:0];
			if (evt.valid && evt.ready) begin
				advance_timer(cmd_t'(evt.command), evt.data_byte, evt.pixel_index, got);
				timer_results.push_back(got);
			end
		end
		awaited = timer_results.size();
	end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top for the LED bar countdown timer: clock, reset, stimulus and verdict
module tb_top;
	import lbct_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;
	localparam int ITEM_TARGET = 550;
	localparam int PHASES = 6;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [PADDR_W-1:0]   paddr;
	logic [31:0]          pwdata;
	logic [31:0]          prdata;
	logic                 pready;
	int                   mismatch_count;
	int                   awaited;
	int                   sent;
	int                   tick_len;
	int                   ticks_per_step[8];
	logic                 src_idle;
	logic                 snk_idle;
	logic                 hold_off_req;
	logic [7:0]           last_led;

	lbct_req_if evt_ch();
	lbct_rsp_if res_ch();

	always #5 clk = ~clk;

	led_bar_countdown_timer i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (evt_ch),
		.rsp     (res_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	lbct_timer_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.evt            (evt_ch),
		.res            (res_ch),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.pready         (pready),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.mismatch_count (mismatch_count),
		.awaited        (awaited)
	);

	function automatic logic [7:0] any8();
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 5))
			0: return CH_G;
			1: return CH_S;
			2: return CH_0;
			3: return CH_1 + 8'($urandom_range(0, 7));
			default: return any8();
		endcase
	endfunction

	task automatic send_evt(input cmd_t cmd, input logic [7:0] b, input logic [7:0] pix);
		int gap;
		gap = src_idle ? $urandom_range(0, 11) : 0;
		if (gap > 0) begin
			evt_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		evt_ch.valid = 1'b1;
		evt_ch.command = cmd;
		evt_ch.data_byte = b;
		evt_ch.pixel_index = pix;
		do @(posedge clk); while (!evt_ch.ready);
		@(negedge clk);
		sent++;
	endtask

	task automatic maybe_pixel();
		if ($urandom_range(0, 2) == 0)
			send_evt(CMD_PIXEL, any8(), 8'($urandom_range(0, last_led) + $urandom_range(0, 2)));
	endtask

	task automatic play_anim();
		repeat (ANIM_FRAMES + $urandom_range(0, 1)) begin
			send_evt(CMD_FRAME, any8(), any8());
			maybe_pixel();
			if ($urandom_range(0, 9) == 0)
				send_evt(CMD_BYTE, pick_byte(), any8());
		end
	endtask

	task automatic run_sequence();
		int k;
		int steps;
		if ($urandom_range(0, 1) == 1) begin
			k = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom_range(0, 1);
			send_evt(CMD_BYTE, CH_1 + 8'(k), any8());
			tick_len = ticks_per_step[k];
		end
		send_evt(CMD_BYTE, ($urandom_range(0, 4) == 0) ? CH_S : CH_G, any8());
		play_anim();
		steps = ((last_led >> 1) + 1) * tick_len + $urandom_range(0, 3);
		if (steps > 70)
			steps = 70;
		repeat (steps) begin
			send_evt(CMD_TICK, any8(), any8());
			maybe_pixel();
			if ($urandom_range(0, 29) == 0)
				send_evt(CMD_BYTE, pick_byte(), any8());
		end
		play_anim();
		repeat ($urandom_range(1, 3))
			send_evt(CMD_PIXEL, any8(), 8'($urandom_range(0, last_led)));
	endtask

	task automatic drain();
		evt_ch.valid = 1'b0;
		while (awaited != 0) @(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_last_led(input logic [7:0] v);
		drain();
		psel = 1'b1;
		pwrite = 1'b1;
		penable = 1'b0;
		paddr = PADDR_W'(4 * REG_LAST_LED);
		pwdata = {24'($urandom), v};
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		last_led = v;
	endtask

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (evt_ch.valid && evt_ch.ready) || (res_ch.valid && res_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb_top NOT OK");
		$finish;
	end

	initial begin : result_sink
		int gap;
		res_ch.ready = 1'b0;
		snk_idle = 1'b1;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (hold_off_req) begin
				res_ch.ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_off_req = 1'b0;
			end
			gap = snk_idle ? $urandom_range(0, 11) : 0;
			if (gap > 0) begin
				res_ch.ready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			res_ch.ready = 1'b1;
			do @(posedge clk); while (!res_ch.valid);
			@(negedge clk);
			if ($urandom_range(0, 39) == 0)
				snk_idle = ~snk_idle;
		end
	end

	initial begin : stimulus
		logic [7:0] v;
		int         phase_end;
		arst_n = 1'b0;
		evt_ch.valid = 1'b0;
		evt_ch.command = CMD_BYTE;
		evt_ch.data_byte = '0;
		evt_ch.pixel_index = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		hold_off_req = 1'b0;
		src_idle = 1'b1;
		sent = 0;
		tick_len = 16;
		last_led = LAST_LED_RESET;
		ticks_per_step = '{4, 8, 12, 16, 24, 32, 48, 64};
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_evt(CMD_PIXEL, 8'h00, 8'hFF);
		send_evt(CMD_PIXEL, 8'hFF, 8'h00);
		send_evt(CMD_TICK, 8'hFF, 8'hFF);
		send_evt(CMD_FRAME, 8'h00, 8'h00);
		send_evt(CMD_BYTE, 8'hFF, 8'h00);
		send_evt(CMD_BYTE, 8'h00, 8'hFF);
		send_evt(CMD_BYTE, CH_1, any8());
		send_evt(CMD_BYTE, CH_2, any8());
		send_evt(CMD_BYTE, CH_3, any8());
		send_evt(CMD_BYTE, CH_4, any8());
		send_evt(CMD_BYTE, CH_5, any8());
		send_evt(CMD_BYTE, CH_6, any8());
		send_evt(CMD_BYTE, CH_7, any8());
		send_evt(CMD_BYTE, CH_8, any8());
		send_evt(CMD_BYTE, CH_1, any8());
		tick_len = 4;
		send_evt(CMD_BYTE, CH_G, any8());
		send_evt(CMD_BYTE, CH_S, any8());
		send_evt(CMD_BYTE, CH_3, any8());
		send_evt(CMD_PIXEL, any8(), 8'd30);
		send_evt(CMD_PIXEL, any8(), 8'd29);
		send_evt(CMD_FRAME, any8(), any8());
		send_evt(CMD_BYTE, CH_0, any8());
		send_evt(CMD_PIXEL, any8(), 8'd59);
		send_evt(CMD_PIXEL, any8(), 8'd60);

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: v = 8'd1;
				1: v = 8'd255;
				2: v = 8'd9;
				3: v = 8'($urandom_range(2, 31));
				4: v = 8'd5;
				default: v = 8'($urandom_range(32, 254));
			endcase
			write_last_led(v);
			if (ph == 2)
				hold_off_req = 1'b1;
			phase_end = sent + (ITEM_TARGET - sent) / (PHASES - ph);
			while (sent < phase_end) begin
				src_idle = ($urandom_range(0, 3) != 0);
				if ($urandom_range(0, 9) < 7) begin
					run_sequence();
				end else begin
					repeat ($urandom_range(10, 30))
						send_evt(cmd_t'($urandom_range(0, 3)), pick_byte(), any8());
				end
			end
		end

		evt_ch.valid = 1'b0;
		while (awaited != 0) @(negedge clk);
		repeat (5) @(negedge clk);
		if (mismatch_count == 0 && awaited == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/lbct_pkg.sv
hdl/lbct_channels.sv
hdl/led_bar_countdown_timer.sv
hdl/lbct_checker.sv
tb/lbct_timer_checker.sv
tb/tb_top.sv
